// ----- hdl/bcm_pkg.sv -----
// Shared constants for the binary confusion metrics unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package bcm_pkg;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS = 16;
  localparam int RATIO_W = FRAC_BITS + 1;
  localparam int FIELD_W = 32;
  localparam logic signed [15:0] THRESH_RESET = 16'sd2048;
  localparam logic [RATIO_W-1:0] Q_ONE = RATIO_W'(1 << FRAC_BITS);

  // ratio slot codes, in order of evaluation
  localparam logic [2:0] R_SENS = 3'd0;
  localparam logic [2:0] R_SPEC = 3'd1;
  localparam logic [2:0] R_HARM = 3'd2;
  localparam logic [2:0] R_PREC = 3'd3;
  localparam logic [2:0] R_F1   = 3'd4;
endpackage
`default_nettype wire

// ----- hdl/bcm_front.sv -----
// Front end: threshold register, classification and the four batch counters.
// Depends on bcm_pkg; pushes finished batch counts toward the queue.
`default_nettype none
module bcm_front import bcm_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [15:0] score,
  input  wire logic signed [7:0]  label,
  input  wire logic              last,
  input  wire logic              q_full,
  output logic                   push,
  output logic [4*CW-1:0]        push_data
);
  logic signed [15:0] thr;
  logic [CW-1:0] tp, fn, tn, fp;
  logic [CW-1:0] tp_next, fn_next, tn_next, fp_next;
  logic pred, pos, acc;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    sat_inc = (&c) ? c : c + CW'(1);
  endfunction

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign pred = score >= thr;
  assign pos = label > 8'sd0;

  // one counter bumps per request
  always_comb begin
    tp_next = tp; fn_next = fn; tn_next = tn; fp_next = fp;
    if (pos && pred) tp_next = sat_inc(tp);
    if (pos && !pred) fn_next = sat_inc(fn);
    if (!pos && !pred) tn_next = sat_inc(tn);
    if (!pos && pred) fp_next = sat_inc(fp);
  end

  assign push = acc && last;
  assign push_data = {tp_next, fn_next, tn_next, fp_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
      tp <= '0; fn <= '0; tn <= '0; fp <= '0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (acc) begin
        if (last) begin
          tp <= '0; fn <= '0; tn <= '0; fp <= '0;
        end else begin
          tp <= tp_next; fn <= fn_next; tn <= tn_next; fp <= fp_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bcm_queue.sv -----
// Two-entry queue of batch counts between front and back.
// Depends on bcm_pkg for defaults only.
`default_nettype none
module bcm_queue import bcm_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [4*CW-1:0] push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 q_valid,
  output logic [4*CW-1:0]      q_data
);
  logic [4*CW-1:0] mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bcm_back.sv -----
// Back end: serial multiplier and shared restoring divider for the five ratios.
// Depends on bcm_pkg; pops batch counts from the queue, drives the result.
`default_nettype none
module bcm_back import bcm_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire logic [4*CW-1:0]  q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [RATIO_W-1:0]    sensitivity,
  output logic [RATIO_W-1:0]    specificity,
  output logic [RATIO_W-1:0]    harmonic_mean,
  output logic [RATIO_W-1:0]    precision_ratio,
  output logic [RATIO_W-1:0]    f1_ratio,
  output logic [FIELD_W-1:0]    true_pos_count,
  output logic [FIELD_W-1:0]    false_neg_count,
  output logic [FIELD_W-1:0]    true_neg_count,
  output logic [FIELD_W-1:0]    false_pos_count
);
  localparam int DW = 2 * CW + 2;
  localparam int MCW = $clog2(CW);
  localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LOAD, ST_CHK, ST_RUN, ST_STORE, ST_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] tp, fn, tn, fp, mb_tn, mb_tp;
  logic [CW:0] p, n;
  logic [2*CW-1:0] sh_tp, acc_tt;
  logic [2*CW:0] sh_p, sh_n, acc_pt, acc_nt;
  logic [MCW-1:0] mcnt;
  logic [DW-1:0] num, den, sel_num, sel_den;
  logic [DW:0] rem, rem2;
  logic [FRAC_BITS-1:0] q;
  logic [3:0] step;
  logic [2:0] idx;
  logic [RATIO_W-1:0] ratio_val;
  logic store;

  function automatic logic [FIELD_W-1:0] sat32(input logic [CW-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    sat32 = (x > XW'({FIELD_W{1'b1}})) ? '1 : x[FIELD_W-1:0];
  endfunction

  assign pop = (state == ST_IDLE) && q_valid;
  assign out_valid = state == ST_OUT;
  assign true_pos_count = sat32(tp);
  assign false_neg_count = sat32(fn);
  assign true_neg_count = sat32(tn);
  assign false_pos_count = sat32(fp);

  // operand pair for the current ratio slot
  always_comb begin
    case (idx)
      R_SENS: begin sel_num = DW'(tp); sel_den = DW'(p); end
      R_SPEC: begin sel_num = DW'(tn); sel_den = DW'(n); end
      R_HARM: begin
        sel_num = DW'({acc_tt, 1'b0});
        sel_den = DW'(acc_pt) + DW'(acc_nt);
      end
      R_PREC: begin sel_num = DW'(tp); sel_den = DW'(tp) + DW'(fp); end
      R_F1: begin
        sel_num = DW'({tp, 1'b0});
        sel_den = DW'({tp, 1'b0}) + DW'(fp) + DW'(fn);
      end
      default: begin sel_num = '0; sel_den = '0; end
    endcase
  end

  assign rem2 = {rem[DW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= R_SENS;
      store <= 1'b0;
    end else begin
      store <= 1'b0;
      case (state)
        // take a batch and set up the three products
        ST_IDLE: if (q_valid) begin
          tp <= q_data[4*CW-1:3*CW];
          fn <= q_data[3*CW-1:2*CW];
          tn <= q_data[2*CW-1:CW];
          fp <= q_data[CW-1:0];
          state <= ST_MUL;
          mcnt <= '0;
          idx <= R_SENS;
          p <= {1'b0, q_data[4*CW-1:3*CW]} + {1'b0, q_data[3*CW-1:2*CW]};
          n <= {1'b0, q_data[2*CW-1:CW]} + {1'b0, q_data[CW-1:0]};
          sh_tp <= (2*CW)'(q_data[4*CW-1:3*CW]);
          sh_p <= (2*CW+1)'({1'b0, q_data[4*CW-1:3*CW]} + {1'b0, q_data[3*CW-1:2*CW]});
          sh_n <= (2*CW+1)'({1'b0, q_data[2*CW-1:CW]} + {1'b0, q_data[CW-1:0]});
          mb_tn <= q_data[2*CW-1:CW];
          mb_tp <= q_data[4*CW-1:3*CW];
          acc_tt <= '0; acc_pt <= '0; acc_nt <= '0;
        end
        // shift-add: TP*TN, P*TN, N*TP one multiplier bit a cycle
        ST_MUL: begin
          if (mb_tn[0]) begin
            acc_tt <= acc_tt + sh_tp;
            acc_pt <= acc_pt + sh_p;
          end
          if (mb_tp[0]) acc_nt <= acc_nt + sh_n;
          sh_tp <= {sh_tp[2*CW-2:0], 1'b0};
          sh_p <= {sh_p[2*CW-1:0], 1'b0};
          sh_n <= {sh_n[2*CW-1:0], 1'b0};
          mb_tn <= {1'b0, mb_tn[CW-1:1]};
          mb_tp <= {1'b0, mb_tp[CW-1:1]};
          mcnt <= mcnt + MCW'(1);
          if (mcnt == MCW'(CW - 1)) state <= ST_LOAD;
        end
        ST_LOAD: begin
          num <= sel_num;
          den <= sel_den;
          state <= ST_CHK;
        end
        // zero and unity cases skip the iterations
        ST_CHK: begin
          if (num == '0 || den == '0) begin
            ratio_val <= '0; store <= 1'b1;
            state <= ST_STORE;
          end else if (num >= den) begin
            ratio_val <= Q_ONE; store <= 1'b1;
            state <= ST_STORE;
          end else begin
            rem <= {1'b0, num};
            q <= '0;
            step <= '0;
            state <= ST_RUN;
          end
        end
        // one quotient bit a cycle; last bit goes straight into ratio_val
        ST_RUN: begin
          if (rem2 >= {1'b0, den}) begin
            rem <= rem2 - {1'b0, den};
            q <= {q[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem <= rem2;
            q <= {q[FRAC_BITS-2:0], 1'b0};
          end
          step <= step + 4'd1;
          if (step == 4'(FRAC_BITS - 1)) begin
            ratio_val <= {1'b0, q[FRAC_BITS-2:0], (rem2 >= {1'b0, den})};
            store <= 1'b1;
            state <= ST_STORE;
          end
        end
        // slot result is filed this cycle
        ST_STORE: ;
        ST_OUT: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      // ratio finished: file it and move to next slot
      if (store) begin
        if (idx == R_F1) state <= ST_OUT;
        else begin
          idx <= idx + 3'd1;
          state <= ST_LOAD;
        end
      end
    end
  end

  // result registers, filled one slot at a time
  always_ff @(posedge clk) begin
    if (store) begin
      case (idx)
        R_SENS: sensitivity <= ratio_val;
        R_SPEC: specificity <= ratio_val;
        R_HARM: harmonic_mean <= ratio_val;
        R_PREC: precision_ratio <= ratio_val;
        R_F1: f1_ratio <= ratio_val;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/binary_confusion_metrics_unit.sv -----
// Binary confusion metrics unit: counts one request per cycle, one result per batch.
// From the last request to result, the batch passes the serial multiplier (one bit a
// cycle) and then the shared divider, which computes the five ratios one after another.
// Throughput: one request per cycle while the queue has room; two finished batches
// queue while the back end works; the back end takes a new batch only once idle.
// Synchronous reset clears counters, queue and sequencer; threshold resets to 2048.
`default_nettype none
module binary_confusion_metrics_unit import bcm_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] score,
  input  wire logic signed [7:0]  label,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [RATIO_W-1:0]      sensitivity,
  output logic [RATIO_W-1:0]      specificity,
  output logic [RATIO_W-1:0]      harmonic_mean,
  output logic [RATIO_W-1:0]      precision_ratio,
  output logic [RATIO_W-1:0]      f1_ratio,
  output logic [FIELD_W-1:0]      true_pos_count,
  output logic [FIELD_W-1:0]      false_neg_count,
  output logic [FIELD_W-1:0]      true_neg_count,
  output logic [FIELD_W-1:0]      false_pos_count
);
  logic q_full, push, pop, q_valid;
  logic [4*COUNT_WIDTH-1:0] push_data, q_data;

  bcm_front #(.CW(COUNT_WIDTH)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready,
    .score, .label, .last, .q_full, .push, .push_data
  );

  bcm_queue #(.CW(COUNT_WIDTH)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .full(q_full), .q_valid, .q_data
  );

  bcm_back #(.CW(COUNT_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_data, .pop, .out_valid, .out_ready,
    .sensitivity, .specificity, .harmonic_mean, .precision_ratio, .f1_ratio,
    .true_pos_count, .false_neg_count, .true_neg_count, .false_pos_count
  );
endmodule
`default_nettype wire

// ----- hdl/bcm_checker.sv -----
// Port-level checks for the binary confusion metrics unit, bound to the top level.
// Depends on bcm_pkg.
`default_nettype none
module bcm_checker import bcm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [RATIO_W-1:0] sensitivity,
  input wire logic [RATIO_W-1:0] precision_ratio,
  input wire logic [RATIO_W-1:0] f1_ratio,
  input wire logic [RATIO_W-1:0] harmonic_mean,
  input wire logic [FIELD_W-1:0] true_pos_count
);
  // pending result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // no true positives means TP-based ratios are zero
  a_tp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && true_pos_count == '0 |->
      sensitivity == '0 && precision_ratio == '0 && f1_ratio == '0)
    else $error("nonzero ratio with no true positives");

  // sensitivity, F1 and harmonic mean never exceed one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sensitivity <= Q_ONE && f1_ratio <= Q_ONE && harmonic_mean <= Q_ONE)
    else $error("ratio above one");

  // harmonic mean is zero whenever there are no true positives
  a_harm: assert property (@(posedge clk) disable iff (rst)
    out_valid && true_pos_count == '0 |-> harmonic_mean == '0)
    else $error("harmonic mean nonzero");
endmodule

bind binary_confusion_metrics_unit bcm_checker u_bcm_checker (
  .clk, .rst, .out_valid, .out_ready, .sensitivity, .precision_ratio,
  .f1_ratio, .harmonic_mean, .true_pos_count
);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for binary_confusion_metrics_unit: random and directed batches,
// scoreboard class predicts counts and Q1.16 ratios. Depends on bcm_pkg.
`default_nettype none
module tb;
  import bcm_pkg::*;

  // expected result of one batch
  typedef struct {
    logic [RATIO_W-1:0] sens, spec, harm, prec, f1;
    logic [31:0] tp, fn, tn, fp;
  } batch_metrics_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // tracks counters, threshold and pending batch results
  class metrics_board;
    longint unsigned tp, fn, tn, fp;
    logic signed [15:0] thresh;
    batch_metrics_t pending[$];

    function void clear();
      tp = 0; fn = 0; tn = 0; fp = 0;
      thresh = THRESH_RESET;
    endfunction

    // saturating count at the counter width
    function longint unsigned bump(longint unsigned c);
      longint unsigned cap;
      cap = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
      return (c >= cap) ? cap : c + 64'd1;
    endfunction

    // floor(n*2^16/d), n <= d, 0 on zero operand
    static function logic [RATIO_W-1:0] q16(logic [127:0] n, logic [127:0] d);
      if (n == 0 || d == 0) return 0;
      if (n >= d) return Q_ONE;
      return RATIO_W'((n << FRAC_BITS) / d);
    endfunction

    function void note_request(logic signed [15:0] s, logic signed [7:0] l, logic lst);
      logic pred;
      longint unsigned p, n;
      batch_metrics_t m;
      pred = s >= thresh;
      if (l > 0) begin
        if (pred) tp = bump(tp); else fn = bump(fn);
      end else begin
        if (pred) fp = bump(fp); else tn = bump(tn);
      end
      if (!lst) return;
      p = tp + fn;
      n = tn + fp;
      m.sens = q16(tp, p);
      m.spec = q16(tn, n);
      m.harm = q16(2 * 128'(tp) * tn, 128'(p) * tn + 128'(n) * tp);
      m.prec = q16(tp, tp + fp);
      m.f1 = q16(2 * tp, 2 * tp + fp + fn);
      m.tp = 32'(tp); m.fn = 32'(fn); m.tn = 32'(tn); m.fp = 32'(fp);
      pending.insert(pending.size(), m);
      tp = 0; fn = 0; tn = 0; fp = 0;
    endfunction

    task check_result(batch_metrics_t g);
      batch_metrics_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (g.sens !== e.sens) report("sensitivity", g.sens, e.sens);
      if (g.spec !== e.spec) report("specificity", g.spec, e.spec);
      if (g.harm !== e.harm) report("harmonic_mean", g.harm, e.harm);
      if (g.prec !== e.prec) report("precision_ratio", g.prec, e.prec);
      if (g.f1 !== e.f1) report("f1_ratio", g.f1, e.f1);
      if (g.tp !== e.tp) report("true_pos_count", g.tp, e.tp);
      if (g.fn !== e.fn) report("false_neg_count", g.fn, e.fn);
      if (g.tn !== e.tn) report("true_neg_count", g.tn, e.tn);
      if (g.fp !== e.fp) report("false_pos_count", g.fp, e.fp);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = 0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] score = 0;
  logic signed [7:0] label = 0;
  logic last = 0;
  logic out_valid, out_ready = 0;
  logic [RATIO_W-1:0] sensitivity, specificity, harmonic_mean, precision_ratio, f1_ratio;
  logic [31:0] true_pos_count, false_neg_count, true_neg_count, false_pos_count;

  binary_confusion_metrics_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .score(score), .label(label),
    .last(last), .out_valid(out_valid), .out_ready(out_ready),
    .sensitivity(sensitivity), .specificity(specificity),
    .harmonic_mean(harmonic_mean), .precision_ratio(precision_ratio),
    .f1_ratio(f1_ratio), .true_pos_count(true_pos_count),
    .false_neg_count(false_neg_count), .true_neg_count(true_neg_count),
    .false_pos_count(false_pos_count)
  );

  always #5 clk = ~clk;

  metrics_board board = new();
  int send_idle_pct = 6, recv_idle_pct = 70;
  int hold_off = 0;
  int quiet_cycles = 0;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 300;

  // receiver: random stalls plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        batch_metrics_t g;
        g.sens = sensitivity; g.spec = specificity; g.harm = harmonic_mean;
        g.prec = precision_ratio; g.f1 = f1_ratio;
        g.tp = true_pos_count; g.fn = false_neg_count;
        g.tn = true_neg_count; g.fp = false_pos_count;
        board.check_result(g);
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on acceptance activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || hold_off > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one request, then wait for its acceptance
  task automatic send_request(input logic signed [15:0] s, input logic signed [7:0] l,
                              input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    score <= s;
    label <= l;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(s, l, lst);
  endtask

  // wait for all results, then let the back end settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.thresh = v;
  endtask

  // random batch: mostly short, scores near the threshold
  task automatic random_batch(input int len);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0) s = 16'($urandom);
      else s = board.thresh + $signed(16'($urandom_range(64))) - 16'sd32;
      send_request(s, 8'($urandom), i == len - 1);
    end
  endtask

  initial begin
    board.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, label zero, threshold edge, empty classes
    send_request(16'sh7fff, 8'sh7f, 0);
    send_request(-16'sd32768, -8'sd128, 0);
    send_request(16'sd2048, 8'sd0, 0);
    send_request(16'sd2047, 8'sd1, 1);
    send_request(16'sd0, 8'sd5, 1);
    send_request(16'sd4000, -8'sd1, 1);
    send_request(16'sd3000, 8'sd1, 0);
    send_request(16'sd3000, 8'sd2, 1);
    send_request(16'sd100, 8'sd0, 0);
    send_request(16'sd100, -8'sd3, 1);
    send_request(16'sh5555, 8'sh55, 0);
    send_request(16'shaaaa, 8'shaa, 1);
    drain();
    write_threshold(-16'sd32768);
    send_request(-16'sd32768, 8'sd1, 0);
    send_request(-16'sd32768, 8'sd0, 1);
    drain();
    write_threshold(16'sd32767);
    send_request(16'sd32767, 8'sd1, 0);
    send_request(16'sd32766, 8'sd1, 0);
    send_request(16'sd32766, 8'sd0, 1);
    drain();

    // random phases with changing idle profiles and thresholds
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 70; recv_idle_pct = 6;
      end else if (ph == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_threshold(ph == 0 ? 16'sd2048 : 16'($urandom));
      if (ph == 2) hold_off <= 3000;
      for (int b = 0; b < 30; b++) random_batch($urandom_range(1, 14));
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
